### rtl/dbfc_pkg.sv
// Package: shared types, codes and default constants for the DMA batch flush controller.
package dbfc_pkg;

  // Default build constants
  localparam int MaxBatchDef      = 11;
  localparam int WordsPerFrameDef = 180;
  localparam int BytesPerFrameDef = 1440;
  localparam int StartupFramesDef = 100;

  // Field widths fixed by the interface
  localparam int CntW   = 4;
  localparam int AgeW   = 11;
  localparam int WordsW = 16;
  localparam int CdW    = 7;
  localparam int BytesW = 14;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  localparam logic [AgeW-1:0] AgeMax = '1;

  // Item opcodes; the unused code behaves as a status poll
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_FRAME = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_NORMAL_TARGET  = 3'd0,
    REG_PREFILL_TARGET = 3'd1,
    REG_PREFILL_LOW    = 3'd2,
    REG_PREFILL_HIGH   = 3'd3,
    REG_EMERG_LOW      = 3'd4,
    REG_EMERG_TARGET   = 3'd5,
    REG_AGE_LIMIT      = 3'd6,
    REG_EMERG_AGE      = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam logic [CntW-1:0]   NormalTargetRst  = 4'd2;
  localparam logic [CntW-1:0]   PrefillTargetRst = 4'd4;
  localparam logic [WordsW-1:0] PrefillLowRst    = 16'd540;
  localparam logic [WordsW-1:0] PrefillHighRst   = 16'd1440;
  localparam logic [WordsW-1:0] EmergLowRst      = 16'd360;
  localparam logic [CntW-1:0]   EmergTargetRst   = 4'd2;
  localparam logic [AgeW-1:0]   AgeLimitRst      = 11'd1500;
  localparam logic [AgeW-1:0]   EmergAgeRst      = 11'd500;

  // Configuration seen by the decision logic
  typedef struct packed {
    logic [CntW-1:0]   normal_target;
    logic [CntW-1:0]   prefill_target;
    logic [WordsW-1:0] prefill_low;
    logic [WordsW-1:0] prefill_high;
    logic [WordsW-1:0] emerg_low;
    logic [CntW-1:0]   emerg_target;
    logic [AgeW-1:0]   age_limit;
    logic [AgeW-1:0]   emerg_age;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    logic [1:0]        opcode;
    logic [WordsW-1:0] free_words;
    logic [WordsW-1:0] occ_words;
    logic              underflow;
    logic              active;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic              flush;
    logic [CntW-1:0]   frames;
    logic [BytesW-1:0] bytes;
    logic              waiting;
    logic              rejected;
    logic              ep_start;
    logic              sticky;
    logic              prefill;
  } res_t;

endpackage

### rtl/dbfc_regs.sv
// Configuration register file with APB-style access.
module dbfc_regs import dbfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_target  <= NormalTargetRst;
      cfg_q.prefill_target <= PrefillTargetRst;
      cfg_q.prefill_low    <= PrefillLowRst;
      cfg_q.prefill_high   <= PrefillHighRst;
      cfg_q.emerg_low      <= EmergLowRst;
      cfg_q.emerg_target   <= EmergTargetRst;
      cfg_q.age_limit      <= AgeLimitRst;
      cfg_q.emerg_age      <= EmergAgeRst;
    end else if (wr_en) begin
      case (idx)
        REG_NORMAL_TARGET:  cfg_q.normal_target  <= pwdata[CntW-1:0];
        REG_PREFILL_TARGET: cfg_q.prefill_target <= pwdata[CntW-1:0];
        REG_PREFILL_LOW:    cfg_q.prefill_low    <= pwdata[WordsW-1:0];
        REG_PREFILL_HIGH:   cfg_q.prefill_high   <= pwdata[WordsW-1:0];
        REG_EMERG_LOW:      cfg_q.emerg_low      <= pwdata[WordsW-1:0];
        REG_EMERG_TARGET:   cfg_q.emerg_target   <= pwdata[CntW-1:0];
        REG_AGE_LIMIT:      cfg_q.age_limit      <= pwdata[AgeW-1:0];
        REG_EMERG_AGE:      cfg_q.emerg_age      <= pwdata[AgeW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (idx)
      REG_NORMAL_TARGET:  prdata = DataW'(cfg_q.normal_target);
      REG_PREFILL_TARGET: prdata = DataW'(cfg_q.prefill_target);
      REG_PREFILL_LOW:    prdata = DataW'(cfg_q.prefill_low);
      REG_PREFILL_HIGH:   prdata = DataW'(cfg_q.prefill_high);
      REG_EMERG_LOW:      prdata = DataW'(cfg_q.emerg_low);
      REG_EMERG_TARGET:   prdata = DataW'(cfg_q.emerg_target);
      REG_AGE_LIMIT:      prdata = DataW'(cfg_q.age_limit);
      REG_EMERG_AGE:      prdata = DataW'(cfg_q.emerg_age);
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/dbfc_core.sv
// Batch state registers and the per-transaction flush decision.
module dbfc_core import dbfc_pkg::*; #(
  parameter int MAX_BATCH       = MaxBatchDef,
  parameter int WORDS_PER_FRAME = WordsPerFrameDef,
  parameter int BYTES_PER_FRAME = BytesPerFrameDef,
  parameter int STARTUP_FRAMES  = StartupFramesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam int NeedBits  = $clog2(WORDS_PER_FRAME * MAX_BATCH + 1);
  localparam int SumW      = ((NeedBits > WordsW) ? NeedBits : WordsW) + 1;
  localparam int ByteBits  = $clog2(BYTES_PER_FRAME * MAX_BATCH + 1);
  localparam int ProdW     = (ByteBits > BytesW) ? ByteBits : BytesW;
  localparam logic [CntW-1:0] MaxCnt    = CntW'(MAX_BATCH);
  localparam logic [CdW-1:0]  StartupCd = CdW'(STARTUP_FRAMES);

  logic [CntW-1:0] pend_q, pend_d;
  logic [AgeW-1:0] age_q, age_d;
  logic [CdW-1:0]  cd_q, cd_d;
  logic            pf_q, pf_d;
  logic            ep_q, ep_d;
  logic            sticky_q, sticky_d;
  logic            prev_q;

  logic            rise, discard, reporting, due, emerg;
  logic [CntW-1:0] target;
  logic [AgeW-1:0] limit;
  logic [SumW-1:0] need;
  logic [ProdW-1:0] bytes_full;
  res_t            res;

  // Decision for the transaction in the input register
  always_comb begin
    rise       = item_i.active && !prev_q;
    discard    = rise || !item_i.active;
    res        = '0;
    target     = '0;
    limit      = '0;
    emerg      = 1'b0;
    due        = 1'b0;
    reporting  = 1'b0;
    need       = '0;
    bytes_full = '0;

    // stream edge handling
    cd_d     = rise ? StartupCd : cd_q;
    pend_d   = discard ? '0 : pend_q;
    age_d    = discard ? '0 : age_q;
    ep_d     = discard ? 1'b0 : ep_q;
    pf_d     = discard ? 1'b1 : pf_q;
    sticky_d = sticky_q;

    // event
    case (opcode_e'(item_i.opcode))
      OP_FRAME: begin
        if (pend_d >= MaxCnt) begin
          res.rejected = 1'b1;
        end else begin
          if (pend_d == '0) age_d = '0;
          if (cd_d != '0) cd_d = cd_d - 1'b1;
          pend_d = pend_d + 1'b1;
        end
      end
      OP_TICK: begin
        if (pend_d != '0 && age_d != AgeMax) age_d = age_d + 1'b1;
      end
      default: ;
    endcase

    // flush decision on a pending batch
    if (pend_d != '0) begin
      reporting = (cd_d == '0) && item_i.active;
      if (item_i.underflow) pf_d = 1'b1;
      if (!reporting || !item_i.underflow) begin
        ep_d = 1'b0;
      end else begin
        sticky_d = 1'b1;
        if (!ep_d) begin
          res.ep_start = 1'b1;
          ep_d         = 1'b1;
        end
      end

      // occupancy hysteresis
      if (item_i.occ_words < cfg_i.prefill_low) begin
        pf_d = 1'b1;
      end else if (item_i.occ_words >= cfg_i.prefill_high) begin
        pf_d = 1'b0;
      end
      target = pf_d ? cfg_i.prefill_target : cfg_i.normal_target;

      emerg = item_i.occ_words < cfg_i.emerg_low;
      if (emerg) begin
        if (target > cfg_i.emerg_target) target = cfg_i.emerg_target;
        limit = cfg_i.emerg_age;
      end else begin
        limit = cfg_i.age_limit;
      end

      due  = !(pend_d < target && age_d < limit && pend_d < MaxCnt);
      need = SumW'(pend_d) * SumW'(WORDS_PER_FRAME);
      if (due) begin
        if (SumW'(item_i.free_words) < need) begin
          res.waiting = 1'b1;
        end else begin
          bytes_full = ProdW'(pend_d) * ProdW'(BYTES_PER_FRAME);
          res.flush  = 1'b1;
          res.frames = pend_d;
          res.bytes  = bytes_full[BytesW-1:0];
          if (SumW'(item_i.occ_words) + need >= SumW'(cfg_i.prefill_high)) pf_d = 1'b0;
          pend_d = '0;
          age_d  = '0;
        end
      end
    end

    res.sticky  = sticky_d;
    res.prefill = pf_d;
  end

  assign res_o = res;

  // State update once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      age_q    <= '0;
      cd_q     <= '0;
      pf_q     <= 1'b1;
      ep_q     <= 1'b0;
      sticky_q <= 1'b0;
      prev_q   <= 1'b0;
    end else if (step_i) begin
      pend_q   <= pend_d;
      age_q    <= age_d;
      cd_q     <= cd_d;
      pf_q     <= pf_d;
      ep_q     <= ep_d;
      sticky_q <= sticky_d;
      prev_q   <= item_i.active;
    end
  end

  // Checks
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MaxCnt)
    else $error("pending count above batch maximum");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.flush |=> pend_q == '0 && age_q == '0)
    else $error("batch not emptied after flush");

  a_flush_xor_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res.flush && res.waiting))
    else $error("flush and waiting raised together");

  a_sticky_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(sticky_q))
    else $error("sticky underflow cleared");

  a_inactive_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.active |=> pend_q <= CntW'(1) && !ep_q)
    else $error("batch kept while stream inactive");

endmodule

### rtl/dma_batch_flush_controller_top.sv
// Path from input transaction accept to result valid: input register, then result register.
// Throughput: one transaction per cycle unless out_ready_i stalls; each yields exactly one result.
// The result register holds a stalled result while the next transaction waits in the input register.
// Reset (rst_ni low, asynchronous): both registers empty, batch state cleared, prefill mode set,
// configuration registers return to their reset values. No clearing pass is needed.
module dma_batch_flush_controller_top import dbfc_pkg::*; #(
  parameter int MAX_BATCH       = MaxBatchDef,
  parameter int WORDS_PER_FRAME = WordsPerFrameDef,
  parameter int BYTES_PER_FRAME = BytesPerFrameDef,
  parameter int STARTUP_FRAMES  = StartupFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [WordsW-1:0] fifo_free_words_i,
  input  logic [WordsW-1:0] fifo_occupied_words_i,
  input  logic              fifo_underflow_i,
  input  logic              stream_active_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              flush_o,
  output logic [CntW-1:0]   flush_frames_o,
  output logic [BytesW-1:0] flush_bytes_o,
  output logic              waiting_for_space_o,
  output logic              frame_rejected_o,
  output logic              underflow_episode_start_o,
  output logic              underflow_sticky_o,
  output logic              prefill_on_o
);

  cfg_t  cfg;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, out_vld_q, adv, accept;

  dbfc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance when the result register is free or being drained
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.opcode     <= opcode_i;
      item_q.free_words <= fifo_free_words_i;
      item_q.occ_words  <= fifo_occupied_words_i;
      item_q.underflow  <= fifo_underflow_i;
      item_q.active     <= stream_active_i;
    end
  end

  dbfc_core #(
    .MAX_BATCH       (MAX_BATCH),
    .WORDS_PER_FRAME (WORDS_PER_FRAME),
    .BYTES_PER_FRAME (BYTES_PER_FRAME),
    .STARTUP_FRAMES  (STARTUP_FRAMES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res;
  end

  assign out_valid_o               = out_vld_q;
  assign flush_o                   = res_q.flush;
  assign flush_frames_o            = res_q.frames;
  assign flush_bytes_o             = res_q.bytes;
  assign waiting_for_space_o       = res_q.waiting;
  assign frame_rejected_o          = res_q.rejected;
  assign underflow_episode_start_o = res_q.ep_start;
  assign underflow_sticky_o        = res_q.sticky;
  assign prefill_on_o              = res_q.prefill;

  // Checks
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(res_q))
    else $error("stalled result changed");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(item_q))
    else $error("waiting transaction lost");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("empty input register not ready");

endmodule
